@@ hdl/wss_pkg.sv @@
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants for the wing sweep scheduler
// Register index codes, schedule and alert constants, divider and alert
// interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_MODE  = 3'd0,
        CFG_ZONE_LOW   = 3'd1,
        CFG_ZONE_MID   = 3'd2,
        CFG_ZONE_TRANS = 3'd3,
        CFG_ZONE_HIGH  = 3'd4,
        CFG_SPEED_LIM  = 3'd5,
        CFG_MACH_LIM   = 3'd6,
        CFG_CEILING    = 3'd7
    } cfg_index_t;

    // Fixed schedule break points in centidegrees
    localparam logic signed [15:0] MID_CDEG   = 16'sd3500;
    localparam logic signed [15:0] TRANS_CDEG = 16'sd5000;
    localparam logic signed [16:0] SWEEP_CAP  = 17'sd8191;

    // Rate computation
    localparam logic [19:0] US_PER_S     = 20'd1000000;
    localparam logic [31:0] DT_MIN_US    = 32'd1000;
    localparam logic [23:0] RATE_MAX     = 24'h7FFFFF;
    localparam logic [23:0] RATE_MIN     = 24'h800000;
    localparam logic [33:0] RATE_MAG_POS = 34'd8388607;
    localparam logic [33:0] RATE_MAG_NEG = 34'd8388608;

    // Slow-flight alert limits
    localparam logic [10:0]        SLOW_SPEED_KT = 11'd100;
    localparam logic signed [18:0] SLOW_ALT_FT   = 19'sd500;

    // Shared divider geometry
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 32;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic bad;
        logic os_air;
        logic os_mach;
        logic ceil;
        logic slow;
        logic any;
    } alert_t;

endpackage

`default_nettype wire

@@ hdl/wss_div.sv @@
// ----------------------------------------------------------------------------
// wss_div: shared restoring divider
// Unsigned 34-bit by 32-bit division, one quotient bit per cycle. The
// quotient holds after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_div
    import wss_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire div_ctl_t             ctl,
    input  wire logic [DIV_NUM_W-1:0] dividend,
    input  wire logic [DIV_DEN_W-1:0] divisor,
    output div_stat_t                 stat,
    output logic      [DIV_NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DIV_NUM_W-1]};
        rem_sub = rem_sh - {1'b0, divisor};
        fits    = (rem_sh >= {1'b0, divisor});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (ctl.start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

@@ hdl/wss_alerts.sv @@
// ----------------------------------------------------------------------------
// wss_alerts: air-data limit checks
// Compares one sample against the configured limits and the fixed
// slow-flight limits.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_alerts
    import wss_pkg::*;
(
    input  wire logic               data_valid,
    input  wire logic signed [12:0] mach_milli,
    input  wire logic        [10:0] airspeed_kt,
    input  wire logic signed [17:0] altitude,
    input  wire logic        [10:0] speed_limit_kt,
    input  wire logic        [11:0] mach_lim_milli,
    input  wire logic        [16:0] ceiling_ft,
    output alert_t                  alerts
);

    logic signed [13:0] mach_ext;
    logic signed [13:0] mach_lim_ext;
    logic signed [18:0] alt_ext;
    logic signed [18:0] ceil_ext;

    // Widen to a common signed range before comparing
    always_comb begin
        mach_ext     = 14'(mach_milli);
        mach_lim_ext = signed'({2'b00, mach_lim_milli});
        alt_ext      = 19'(altitude);
        ceil_ext     = signed'({2'b00, ceiling_ft});

        alerts = '0;
        if (!data_valid) begin
            alerts.bad = 1'b1;
        end else begin
            alerts.os_air  = (airspeed_kt > speed_limit_kt);
            alerts.os_mach = (mach_ext > mach_lim_ext);
            alerts.ceil    = (alt_ext > ceil_ext);
            alerts.slow    = (airspeed_kt < SLOW_SPEED_KT) && (alt_ext > SLOW_ALT_FT);
        end
        alerts.any = alerts.bad | alerts.os_air | alerts.os_mach | alerts.ceil
                   | alerts.slow;
    end

endmodule

`default_nettype wire

@@ hdl/wing_sweep_schedule_and_alerts_unit.sv @@
// ----------------------------------------------------------------------------
// wing_sweep_schedule_and_alerts_unit: wing sweep schedule with limit alerts
// Takes one air-data sample per transaction on the s_ channel and returns one
// result transaction on the m_ channel: scheduled sweep, sweep rate, position
// flags and limit alerts. Registers must be written through cfg_we / cfg_idx /
// cfg_wdata only while no sample is in flight; the block does not enforce this.
//
// A sample that recomputes the sweep uses the shared bit-serial divider for
// the interpolation and again for the rate; the rate division is skipped
// when the time step is not above DT_MIN_US, and the interpolation division
// when the zone is empty. A sample that only updates alerts goes straight
// to the result.
// s_ready is high only while the sequencer is idle, so a new sample is taken
// at the earliest in the cycle after the previous result is loaded.
// The finished result sits in an output register: the next sample is
// accepted while it waits, and a stalled m_ready holds the sequencer at its
// last step until the register frees.
// Reset (synchronous, aresetn low) loads the register defaults, puts the
// sweep at its minimum with zero rate and clears the time history.
// ----------------------------------------------------------------------------
`default_nettype none

module wing_sweep_schedule_and_alerts_unit
    import wss_pkg::*;
#(
    parameter int SWEEP_MIN_CDEG = 2000,
    parameter int SWEEP_MAX_CDEG = 6800
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Sample channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_data_valid,
    input  wire logic signed [12:0]    s_mach_milli,
    input  wire logic        [10:0]    s_airspeed_kt,
    input  wire logic signed [17:0]    s_altitude,
    input  wire logic        [31:0]    s_timestamp_us,
    // Result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic        [12:0]         m_sweep_cdeg,
    output logic signed [23:0]         m_sweep_rate,
    output logic                       m_at_minimum,
    output logic                       m_at_maximum,
    output logic                       m_sensor_bad,
    output logic                       m_overspeed_air,
    output logic                       m_overspeed_mach,
    output logic                       m_above_ceiling,
    output logic                       m_slow_flight,
    output logic                       m_any_alarm
);

    localparam logic signed [15:0] Y_MIN   = 16'(SWEEP_MIN_CDEG);
    localparam logic signed [15:0] Y_MAX   = 16'(SWEEP_MAX_CDEG);
    localparam logic        [13:0] SWEEP_RST = 14'(SWEEP_MIN_CDEG);
    localparam logic        [15:0] MIN_FLAG_LIM = 16'(SWEEP_MIN_CDEG + 10);
    localparam logic        [15:0] MAX_FLAG_LIM = 16'(SWEEP_MAX_CDEG - 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCHED    = 7'b0000010,
        ST_DIV_GO   = 7'b0000100,
        ST_DIV_WAIT = 7'b0001000,
        ST_SWEEP    = 7'b0010000,
        ST_RATE_MUL = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic        auto_mode_reg;
    logic [11:0] zone_low_reg, zone_mid_reg, zone_trans_reg, zone_high_reg;
    logic [10:0] speed_lim_reg;
    logic [11:0] mach_lim_reg;
    logic [16:0] ceiling_reg;

    // Persistent wing state
    logic [13:0]        sweep_now_reg, sweep_now_next;
    logic signed [23:0] rate_now_reg, rate_now_next;
    logic               min_flag_reg, min_flag_next;
    logic               max_flag_reg, max_flag_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic               seen_first_reg, seen_first_next;

    // Per-sample working registers
    logic [11:0]          mach_reg, mach_next;
    logic [31:0]          dt_reg, dt_next;
    alert_t               alert_reg, alert_next;
    logic                 empty_reg, empty_next;
    logic signed [15:0]   y0_reg, y0_next;
    logic [DIV_NUM_W-1:0] mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic                 rate_phase_reg, rate_phase_next;
    logic [13:0]          dmag_reg, dmag_next;

    // Result register
    logic               m_valid_reg, m_valid_next;
    logic [12:0]        out_sweep_reg, out_sweep_next;
    logic signed [23:0] out_rate_reg, out_rate_next;
    logic               out_min_reg, out_min_next;
    logic               out_max_reg, out_max_next;
    alert_t             out_alert_reg, out_alert_next;

    // Shared divider
    div_ctl_t             div_ctl;
    div_stat_t            div_stat;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_NUM_W-1:0] div_quotient;

    // Alert checks on the incoming sample
    alert_t in_alerts;

    wss_alerts u_alerts (
        .data_valid     (s_data_valid),
        .mach_milli     (s_mach_milli),
        .airspeed_kt    (s_airspeed_kt),
        .altitude       (s_altitude),
        .speed_limit_kt (speed_lim_reg),
        .mach_lim_milli (mach_lim_reg),
        .ceiling_ft     (ceiling_reg),
        .alerts         (in_alerts)
    );

    wss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // Zone selection and interpolation numerator
    logic               z_empty;
    logic [11:0]        z_x0, z_x1, z_span, z_pos_raw, z_pos;
    logic signed [15:0] z_y0, z_y1, z_dy;
    logic [14:0]        z_dy_mag;
    logic [26:0]        z_prod;

    always_comb begin
        z_empty = 1'b0;
        z_x0    = zone_low_reg;
        z_x1    = zone_mid_reg;
        z_y0    = Y_MIN;
        z_y1    = MID_CDEG;
        if (mach_reg < zone_low_reg) begin
            z_empty = 1'b1;
        end else if (mach_reg < zone_mid_reg) begin
            z_x0 = zone_low_reg;
        end else if (mach_reg < zone_trans_reg) begin
            z_x0 = zone_mid_reg;
            z_x1 = zone_trans_reg;
            z_y0 = MID_CDEG;
            z_y1 = TRANS_CDEG;
        end else begin
            z_x0 = zone_trans_reg;
            z_x1 = zone_high_reg;
            z_y0 = TRANS_CDEG;
            z_y1 = Y_MAX;
        end
        if (z_x1 <= z_x0) begin
            z_empty = 1'b1;
        end
        z_span    = z_x1 - z_x0;
        z_pos_raw = (mach_reg > z_x0) ? (mach_reg - z_x0) : 12'd0;
        z_pos     = (z_pos_raw > z_span) ? z_span : z_pos_raw;
        z_dy      = z_y1 - z_y0;
        z_dy_mag  = z_dy[15] ? 15'(-z_dy) : z_dy[14:0];
        z_prod    = z_pos * z_dy_mag;
    end

    // Sweep from interpolation quotient, and sweep delta
    logic [14:0]        sw_q;
    logic signed [16:0] sw_raw;
    logic [13:0]        sw_new;
    logic signed [14:0] sw_diff;

    always_comb begin
        sw_q   = empty_reg ? 15'd0 : div_quotient[14:0];
        sw_raw = neg_reg ? (17'(y0_reg) - signed'({2'b00, sw_q}))
                         : (17'(y0_reg) + signed'({2'b00, sw_q}));
        if (sw_raw < 17'sd0) begin
            sw_new = 14'd0;
        end else if (sw_raw > SWEEP_CAP) begin
            sw_new = 14'(SWEEP_CAP);
        end else begin
            sw_new = sw_raw[13:0];
        end
        sw_diff = signed'({1'b0, sw_new}) - signed'({1'b0, sweep_now_reg});
    end

    // Saturated rate from rate quotient
    logic [23:0] rate_sat;

    always_comb begin
        if (!neg_reg) begin
            rate_sat = (div_quotient > RATE_MAG_POS) ? RATE_MAX : div_quotient[23:0];
        end else begin
            rate_sat = (div_quotient > RATE_MAG_NEG) ? RATE_MIN
                                                     : (24'd0 - div_quotient[23:0]);
        end
    end

    // Rounded dividend: magnitude plus half the divisor
    assign div_dividend = mag_reg + DIV_NUM_W'(den_reg >> 1);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        sweep_now_next  = sweep_now_reg;
        rate_now_next   = rate_now_reg;
        min_flag_next   = min_flag_reg;
        max_flag_next   = max_flag_reg;
        last_time_next  = last_time_reg;
        seen_first_next = seen_first_reg;
        mach_next       = mach_reg;
        dt_next         = dt_reg;
        alert_next      = alert_reg;
        empty_next      = empty_reg;
        y0_next         = y0_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        den_next        = den_reg;
        rate_phase_next = rate_phase_reg;
        dmag_next       = dmag_reg;
        m_valid_next    = m_valid_reg;
        out_sweep_next  = out_sweep_reg;
        out_rate_next   = out_rate_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_alert_next  = out_alert_reg;
        div_ctl.start   = 1'b0;

        // Retire the pending result
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dt_next         = seen_first_reg ? (s_timestamp_us - last_time_reg)
                                                     : 32'd0;
                    last_time_next  = s_timestamp_us;
                    seen_first_next = 1'b1;
                    alert_next      = in_alerts;
                    mach_next       = s_mach_milli[12] ? 12'd0 : s_mach_milli[11:0];
                    state_next      = (auto_mode_reg && s_data_valid) ? ST_SCHED : ST_DONE;
                end
            end
            ST_SCHED: begin
                empty_next      = z_empty;
                y0_next         = z_y0;
                mag_next        = DIV_NUM_W'(z_prod);
                neg_next        = z_dy[15];
                den_next        = DIV_DEN_W'(z_span);
                rate_phase_next = 1'b0;
                state_next      = z_empty ? ST_SWEEP : ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_ctl.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    if (rate_phase_reg) begin
                        rate_now_next = signed'(rate_sat);
                        state_next    = ST_DONE;
                    end else begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                sweep_now_next = sw_new;
                min_flag_next  = (16'(sw_new) <= MIN_FLAG_LIM);
                max_flag_next  = (16'(sw_new) >= MAX_FLAG_LIM);
                neg_next       = sw_diff[14];
                dmag_next      = sw_diff[14] ? 14'(-sw_diff) : sw_diff[13:0];
                if (dt_reg > DT_MIN_US) begin
                    state_next = ST_RATE_MUL;
                end else begin
                    rate_now_next = '0;
                    state_next    = ST_DONE;
                end
            end
            ST_RATE_MUL: begin
                mag_next        = DIV_NUM_W'(dmag_reg * US_PER_S);
                den_next        = dt_reg;
                rate_phase_next = 1'b1;
                state_next      = ST_DIV_GO;
            end
            ST_DONE: begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_sweep_next = sweep_now_reg[12:0];
                    out_rate_next  = rate_now_reg;
                    out_min_next   = min_flag_reg;
                    out_max_next   = max_flag_reg;
                    out_alert_next = alert_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sweep_now_reg  <= SWEEP_RST;
            rate_now_reg   <= '0;
            min_flag_reg   <= 1'b1;
            max_flag_reg   <= 1'b0;
            last_time_reg  <= '0;
            seen_first_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_now_reg  <= sweep_now_next;
            rate_now_reg   <= rate_now_next;
            min_flag_reg   <= min_flag_next;
            max_flag_reg   <= max_flag_next;
            last_time_reg  <= last_time_next;
            seen_first_reg <= seen_first_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Working and result payload registers
    always_ff @(posedge aclk) begin
        mach_reg       <= mach_next;
        dt_reg         <= dt_next;
        alert_reg      <= alert_next;
        empty_reg      <= empty_next;
        y0_reg         <= y0_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        den_reg        <= den_next;
        rate_phase_reg <= rate_phase_next;
        dmag_reg       <= dmag_next;
        out_sweep_reg  <= out_sweep_next;
        out_rate_reg   <= out_rate_next;
        out_min_reg    <= out_min_next;
        out_max_reg    <= out_max_next;
        out_alert_reg  <= out_alert_next;
    end

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_mode_reg  <= 1'b1;
            zone_low_reg   <= 12'd400;
            zone_mid_reg   <= 12'd800;
            zone_trans_reg <= 12'd1000;
            zone_high_reg  <= 12'd2340;
            speed_lim_reg  <= 11'd800;
            mach_lim_reg   <= 12'd2340;
            ceiling_reg    <= 17'd50000;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_idx))
                CFG_AUTO_MODE:  auto_mode_reg  <= cfg_wdata[0];
                CFG_ZONE_LOW:   zone_low_reg   <= cfg_wdata[11:0];
                CFG_ZONE_MID:   zone_mid_reg   <= cfg_wdata[11:0];
                CFG_ZONE_TRANS: zone_trans_reg <= cfg_wdata[11:0];
                CFG_ZONE_HIGH:  zone_high_reg  <= cfg_wdata[11:0];
                CFG_SPEED_LIM:  speed_lim_reg  <= cfg_wdata[10:0];
                CFG_MACH_LIM:   mach_lim_reg   <= cfg_wdata[11:0];
                CFG_CEILING:    ceiling_reg    <= cfg_wdata[16:0];
                default: begin
                end
            endcase
        end
    end

    // Port drive
    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_sweep_cdeg     = out_sweep_reg;
    assign m_sweep_rate     = out_rate_reg;
    assign m_at_minimum     = out_min_reg;
    assign m_at_maximum     = out_max_reg;
    assign m_sensor_bad     = out_alert_reg.bad;
    assign m_overspeed_air  = out_alert_reg.os_air;
    assign m_overspeed_mach = out_alert_reg.os_mach;
    assign m_above_ceiling  = out_alert_reg.ceil;
    assign m_slow_flight    = out_alert_reg.slow;
    assign m_any_alarm      = out_alert_reg.any;

endmodule

`default_nettype wire
